/* src/c8x_pkg.sv */
// ----------------------------------------------------------------------------
// c8x_pkg: shared types and constants of the CHIP-8 immediate execute unit
// Holds instruction kind codes, the queued item record and field widths.
// ----------------------------------------------------------------------------
package c8x_pkg;

   localparam int MemBytes   = 4096;
   localparam int FontBase   = 0;
   localparam int GlyphBytes = 5;
   localparam int NumRegs    = 16;
   localparam int AddrW      = $clog2(MemBytes);
   localparam int RegIdxW    = $clog2(NumRegs);
   localparam int QueueDepth = 2;

   typedef enum logic [4:0] {
      KIND_SEI    = 5'd0,
      KIND_SNI    = 5'd1,
      KIND_LI     = 5'd2,
      KIND_ADDI   = 5'd3,
      KIND_RND    = 5'd4,
      KIND_SIP    = 5'd5,
      KIND_SNIP   = 5'd6,
      KIND_LD     = 5'd7,
      KIND_LK     = 5'd8,
      KIND_DEL    = 5'd9,
      KIND_SND    = 5'd10,
      KIND_II     = 5'd11,
      KIND_FONT   = 5'd12,
      KIND_BCD    = 5'd13,
      KIND_SAVE   = 5'd14,
      KIND_REST   = 5'd15,
      KIND_TICK   = 5'd16,
      KIND_HOSTWR = 5'd17,
      KIND_HOSTRD = 5'd18
   } kind_type;

   // one classified instruction, as it travels from front to back
   typedef struct packed {
      logic [4:0]  kind;
      logic        known;
      logic [3:0]  reg_index;
      logic [7:0]  immediate;
      logic [15:0] key_states;
      logic [3:0]  key_code;
      logic [7:0]  random_byte;
      logic [11:0] host_address;
      logic [7:0]  host_data;
   } item_type;

   localparam int ItemW = $bits(item_type);

endpackage

/* src/c8x_ram.sv */
// ----------------------------------------------------------------------------
// c8x_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module c8x_ram #(
   parameter int Width = 8,
   parameter int Depth = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[addr] <= wr_data;
      rd_data <= mem_ff[addr];
   end
endmodule

/* src/c8x_front.sv */
// ----------------------------------------------------------------------------
// c8x_front: accept and classify instructions, queue them for execution
// Two-entry queue decouples the input channel from the back end.
// ----------------------------------------------------------------------------
module c8x_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  c8x_pkg::item_type in_item,
   output logic              q_valid,
   input  logic              q_take,
   output c8x_pkg::item_type q_item
);
   import c8x_pkg::*;

   item_type   slot_ff [QueueDepth];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;
   item_type   cls;

   always_comb begin
      cls = in_item;
      cls.known = (in_item.kind <= KIND_HOSTRD);
   end

   assign in_ready = (cnt_ff != 2'(QueueDepth));
   assign push     = in_valid && in_ready;
   assign q_valid  = (cnt_ff != 2'd0);
   assign pop      = q_valid && q_take;
   assign q_item   = slot_ff[rp_ff];
   assign wp_in    = push ? ~wp_ff : wp_ff;
   assign rp_in    = pop ? ~rp_ff : rp_ff;
   assign cnt_in   = cnt_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wp_ff] <= cls;
   end
endmodule

/* src/c8x_back.sv */
// ----------------------------------------------------------------------------
// c8x_back: execute queued instructions against registers and memory
// Sequencer steps BCD, save and restore one memory byte per cycle.
// ----------------------------------------------------------------------------
module c8x_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_take,
   input  c8x_pkg::item_type q_item,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [2:0]        out_adv,
   output logic              out_status,
   output logic [7:0]        out_rdata,
   output logic              out_sound
);
   import c8x_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_BCD  = 6'b000010,
      ST_SAVE = 6'b000100,
      ST_REST = 6'b001000,
      ST_RDW  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   state_type   st_ff, st_in;
   item_type    it_ff, it_in;
   logic [7:0]  gpr_ff [NumRegs];
   logic [15:0] ar_ff, ar_in;
   logic [7:0]  dly_ff, dly_in, snd_ff, snd_in;
   logic [15:0] a_ff, a_in;
   logic [4:0]  i_ff, i_in;
   logic [7:0]  bv_ff, bv_in;
   logic [2:0]  adv_ff, adv_in;
   logic        sts_ff, sts_in;
   logic [7:0]  rd_ff, rd_in;
   logic        ov_ff, ov_in;
   logic        restw_ff, restw_in;
   logic [RegIdxW-1:0] restr_ff, restr_in;

   logic              wr_en;
   logic [AddrW-1:0]  m_addr;
   logic [7:0]        m_wdata, m_rdata;
   logic              gw_en;
   logic [RegIdxW-1:0] gw_idx;
   logic [7:0]        gw_val, vx, q10;
   logic [3:0]        r10;
   logic              in_range;

   c8x_ram #(.Width(8), .Depth(MemBytes)) u_mem (
      .clock(clock), .wr_en(wr_en), .addr(m_addr),
      .wr_data(m_wdata), .rd_data(m_rdata)
   );

   assign vx       = gpr_ff[it_ff.reg_index];
   assign in_range = (a_ff < 16'(MemBytes));
   assign q10      = 8'((16'(bv_ff) * 16'd205) >> 11);
   assign r10      = 4'(bv_ff - 8'(q10 * 8'd10));
   assign q_take   = (st_ff == ST_IDLE) && !ov_ff && !restw_ff && q_valid;
   assign out_valid = ov_ff;
   assign out_adv   = adv_ff;
   assign out_status = sts_ff;
   assign out_rdata = rd_ff;
   assign out_sound = (snd_ff != 8'd0);

   always_comb begin
      st_in = st_ff; it_in = it_ff; ar_in = ar_ff; dly_in = dly_ff;
      snd_in = snd_ff; a_in = a_ff; i_in = i_ff; bv_in = bv_ff;
      adv_in = adv_ff; sts_in = sts_ff; rd_in = rd_ff; ov_in = ov_ff;
      restw_in = 1'b0; restr_in = restr_ff;
      wr_en = 1'b0; m_addr = a_ff[AddrW-1:0]; m_wdata = 8'd0;
      gw_en = 1'b0; gw_idx = it_ff.reg_index; gw_val = 8'd0;
      if (ov_ff && out_ready) ov_in = 1'b0;
      if (restw_ff) begin
         gw_en = 1'b1; gw_idx = restr_ff; gw_val = m_rdata;
      end
      unique case (st_ff)
         ST_IDLE: begin
            if (q_take) begin
               it_in = q_item; st_in = ST_RDW;
            end
         end
         ST_RDW: begin
            // decode with register file value available
            adv_in = 3'd2; sts_in = 1'b0; rd_in = 8'd0;
            st_in = ST_OUT;
            a_in = ar_ff; i_in = 5'd0; bv_in = vx;
            if (!it_ff.known) adv_in = 3'd0;
            else begin
               unique case (kind_type'(it_ff.kind))
                  KIND_SEI:  if (vx == it_ff.immediate) adv_in = 3'd4;
                  KIND_SNI:  if (vx != it_ff.immediate) adv_in = 3'd4;
                  KIND_LI:   begin gw_en = 1'b1; gw_val = it_ff.immediate; end
                  KIND_ADDI: begin gw_en = 1'b1; gw_val = vx + it_ff.immediate; end
                  KIND_RND:  begin
                     gw_en = 1'b1; gw_val = it_ff.random_byte & it_ff.immediate;
                  end
                  KIND_SIP:  if (vx < 8'd16 && it_ff.key_states[vx[3:0]]) adv_in = 3'd4;
                  KIND_SNIP: if (vx < 8'd16 && !it_ff.key_states[vx[3:0]]) adv_in = 3'd4;
                  KIND_LD:   begin gw_en = 1'b1; gw_val = dly_ff; end
                  KIND_LK:   begin gw_en = 1'b1; gw_val = 8'(it_ff.key_code); end
                  KIND_DEL:  dly_in = vx;
                  KIND_SND:  snd_in = vx;
                  KIND_II:   ar_in = ar_ff + 16'(vx);
                  KIND_FONT: if (vx < 8'd16)
                     ar_in = 16'(FontBase) + 16'(vx) * 16'(GlyphBytes);
                  KIND_BCD:  begin a_in = ar_ff + 16'd2; st_in = ST_BCD; end
                  KIND_SAVE: st_in = ST_SAVE;
                  KIND_REST: st_in = ST_REST;
                  KIND_TICK: begin
                     adv_in = 3'd0;
                     if (dly_ff != 8'd0) dly_in = dly_ff - 8'd1;
                     if (snd_ff != 8'd0) snd_in = snd_ff - 8'd1;
                  end
                  KIND_HOSTWR: begin
                     adv_in = 3'd0; wr_en = 1'b1;
                     m_addr = it_ff.host_address[AddrW-1:0];
                     m_wdata = it_ff.host_data;
                  end
                  KIND_HOSTRD: begin
                     adv_in = 3'd0; m_addr = it_ff.host_address[AddrW-1:0];
                     restw_in = 1'b0; st_in = ST_BCD; i_in = 5'd16;
                  end
                  default: adv_in = 3'd0;
               endcase
            end
         end
         ST_BCD: begin
            if (i_ff == 5'd16) begin
               // host read data lands this cycle
               rd_in = m_rdata; st_in = ST_OUT;
            end else begin
               wr_en = in_range; m_wdata = 8'(r10);
               bv_in = q10; a_in = a_ff - 16'd1; i_in = i_ff + 5'd1;
               if (i_ff == 5'd2) st_in = ST_OUT;
            end
         end
         ST_SAVE, ST_REST: begin
            if (!in_range) begin
               adv_in = 3'd0; sts_in = 1'b1; st_in = ST_OUT;
            end else begin
               if (st_ff == ST_SAVE) begin
                  wr_en = 1'b1; m_wdata = gpr_ff[i_ff[RegIdxW-1:0]];
               end else begin
                  restw_in = 1'b1; restr_in = i_ff[RegIdxW-1:0];
               end
               a_in = a_ff + 16'd1; i_in = i_ff + 5'd1;
               if (i_ff[RegIdxW-1:0] == it_ff.reg_index) st_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!ov_ff && !restw_ff) begin
               ov_in = 1'b1; st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; ov_ff <= 1'b0; restw_ff <= 1'b0;
         ar_ff <= 16'd0; dly_ff <= 8'd0; snd_ff <= 8'd0;
         for (int k = 0; k < NumRegs; k++) gpr_ff[k] <= 8'd0;
      end else begin
         st_ff <= st_in; ov_ff <= ov_in; restw_ff <= restw_in;
         ar_ff <= ar_in; dly_ff <= dly_in; snd_ff <= snd_in;
         if (gw_en) gpr_ff[gw_idx] <= gw_val;
      end
      it_ff <= it_in; a_ff <= a_in; i_ff <= i_in; bv_ff <= bv_in;
      adv_ff <= adv_in; sts_ff <= sts_in; rd_ff <= rd_in; restr_ff <= restr_in;
   end
endmodule

/* src/chip8_immediate_exec_unit.sv */
// ----------------------------------------------------------------------------
// chip8_immediate_exec_unit: CHIP-8 register/immediate instruction executor
// Top level: stream ports, front classifier and queue, back execution unit.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. After the back end takes an instruction off
// the queue, most kinds pass through take, decode and execute, and the output
// register before the result beat is offered; host read adds a memory read
// step, BCD adds three digit writes, save adds one byte write per register,
// and restore adds one byte read per register plus a wait for the last read
// to land, set by the single-port byte memory. An accepted beat is registered
// in the queue before the back end can take it, and the back end dequeues the
// next instruction only after its result beat is taken. A two-beat queue lets
// the input side accept while the back end works or its result waits. Memory
// bytes have no reset value; read only bytes already written.
module chip8_immediate_exec_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // kind[4:0], reg_index[8:5], immediate[16:9], key_states[32:17],
   // key_code[36:33], random_byte[44:37], host_address[56:45],
   // host_data[64:57], zero fill to 72
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pc_advance[2:0], status[3], read_data[11:4], sound_on[12], zero fill
   output logic [15:0] rsp_tdata
);
   import c8x_pkg::*;

   item_type in_item, q_item;
   logic     q_valid, q_take;
   logic [2:0] adv;
   logic       sts, snd;
   logic [7:0] rd;

   // unpack the beat; classification bit is set by the front end
   always_comb begin
      in_item.kind         = req_tdata[4:0];
      in_item.known        = 1'b0;
      in_item.reg_index    = req_tdata[8:5];
      in_item.immediate    = req_tdata[16:9];
      in_item.key_states   = req_tdata[32:17];
      in_item.key_code     = req_tdata[36:33];
      in_item.random_byte  = req_tdata[44:37];
      in_item.host_address = req_tdata[56:45];
      in_item.host_data    = req_tdata[64:57];
   end

   c8x_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .in_item(in_item), .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
   );

   c8x_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_take(q_take),
      .q_item(q_item), .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_adv(adv), .out_status(sts), .out_rdata(rd), .out_sound(snd)
   );

   assign rsp_tdata = {3'd0, snd, rd, sts, adv};
endmodule

/* src/c8x_checker.sv */
// ----------------------------------------------------------------------------
// c8x_checker: port-level checks for the execute unit
// Watches handshakes and result encodings at the top level.
// ----------------------------------------------------------------------------
module c8x_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped while stalled");
   a_adv: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] == 3'd0 || rsp_tdata[2:0] == 3'd2
                     || rsp_tdata[2:0] == 3'd4)
      else $error("bad pc advance");
   a_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> rsp_tdata[2:0] == 3'd0)
      else $error("failure without zero advance");
   a_rst: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result right after reset");
   a_rdy: assert property (@(posedge clock)
      !reset && $past(reset) |-> req_tready)
      else $error("input not ready right after reset");
endmodule

bind chip8_immediate_exec_unit c8x_checker u_c8x_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
